// ----- design/pfg_pkg.sv -----
// ----------------------------------------------------------------------------
// pfg_pkg
// Shared types, codes and widths for the power channel fault guard.
// ----------------------------------------------------------------------------
`default_nettype none

package pfg_pkg;

   // Field widths
   localparam int SAMPLE_BITS    = 16;
   localparam int TIME_BITS      = 32;
   localparam int DUTY_BITS      = 32;
   localparam int CMD_BITS       = 2;
   localparam int CODE_BITS      = 3;
   localparam int NUM_CODES      = 5;
   localparam int TIMEOUT_BITS   = 12;
   localparam int RESP_BITS      = 2;
   localparam int PERIODS_BITS   = NUM_CODES * TIMEOUT_BITS;
   localparam int RESP_TBL_BITS  = NUM_CODES * RESP_BITS;

   // Configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = PERIODS_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] REG_VOLT_HIGH     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_VOLT_LOW      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CURR_HIGH     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CURR_LOW      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TIMEOUT_MASK  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TIMEOUT_PER   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RESPONSE      = 3'd6;

   // Fault codes
   localparam logic [CODE_BITS-1:0] CODE_OVER_V  = 3'd0;
   localparam logic [CODE_BITS-1:0] CODE_UNDER_V = 3'd1;
   localparam logic [CODE_BITS-1:0] CODE_OVER_I  = 3'd2;
   localparam logic [CODE_BITS-1:0] CODE_UNDER_I = 3'd3;
   localparam logic [CODE_BITS-1:0] CODE_NONE    = 3'd4;

   // Responses
   localparam logic [RESP_BITS-1:0] RESP_IGNORE  = 2'd0;
   localparam logic [RESP_BITS-1:0] RESP_WARN    = 2'd1;
   localparam logic [RESP_BITS-1:0] RESP_SHUTOFF = 2'd2;

   // Drive commands
   localparam logic [CMD_BITS-1:0] CMD_ON   = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_OFF  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_PWM  = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_NONE = 2'd3;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0]   volt_high;
      logic [SAMPLE_BITS-1:0]   volt_low;
      logic [SAMPLE_BITS-1:0]   curr_high;
      logic [SAMPLE_BITS-1:0]   curr_low;
      logic [NUM_CODES-1:0]     timeout_mask;
      logic [PERIODS_BITS-1:0]  timeout_periods;
      logic [RESP_TBL_BITS-1:0] response_table;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] voltage_sample;
      logic [SAMPLE_BITS-1:0] current_sample;
      logic [TIME_BITS-1:0]   time_now;
      logic [CMD_BITS-1:0]    cmd_type;
      logic [DUTY_BITS-1:0]   pwm_duty;
   } item_type;

   typedef struct packed {
      logic [CODE_BITS-1:0] fault_code;
      logic                 fault_changed;
      logic                 log_request;
      logic                 drive_valid;
      logic [DUTY_BITS-1:0] drive_value;
   } result_type;

   // Response field of a code; codes outside the table read as ignore
   function automatic logic [RESP_BITS-1:0] response_of(
      input logic [RESP_TBL_BITS-1:0] table_bits,
      input logic [CODE_BITS-1:0]     code
   );
      logic [RESP_BITS-1:0] resp;
      begin
         case (code)
            CODE_OVER_V:  resp = table_bits[0*RESP_BITS +: RESP_BITS];
            CODE_UNDER_V: resp = table_bits[1*RESP_BITS +: RESP_BITS];
            CODE_OVER_I:  resp = table_bits[2*RESP_BITS +: RESP_BITS];
            CODE_UNDER_I: resp = table_bits[3*RESP_BITS +: RESP_BITS];
            CODE_NONE:    resp = table_bits[4*RESP_BITS +: RESP_BITS];
            default:      resp = RESP_IGNORE;
         endcase
         return resp;
      end
   endfunction

endpackage

`default_nettype wire

// ----- design/power_channel_fault_guard.sv -----
// ----------------------------------------------------------------------------
// power_channel_fault_guard
// Fault guard for one power output channel: limit checks, latched fault
// with timeout clearing, log request and drive output selection.
// ----------------------------------------------------------------------------
// An item loads the input register at the req transfer and moves into the result
//   register (rsp_tvalid) once that is empty or being taken; one evaluation stage.
// Throughput: one item per cycle, limited only by the rsp side taking results.
// Reset (synchronous, active high): both channels empty, fault = none,
//   fault time = 0, high limits all ones, other config zero; data not reset.
// csr_ready is always high; writes take effect at the next edge.
`default_nettype none

module power_channel_fault_guard (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [15:0] voltage_sample, [31:16] current_sample, [63:32] time_now,
   // [95:64] pwm_duty
   input  wire logic [95:0] req_tdata,
   // [1:0] cmd_type
   input  wire logic [pfg_pkg::CMD_BITS-1:0] req_tuser,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [2:0] fault_code, [3] fault_changed, [4] log_request, [36:5] drive_value,
   // [39:37] zero
   output logic [39:0]      rsp_tdata,
   // [0] drive_valid
   output logic             rsp_tuser,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [pfg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [pfg_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   localparam int SB = pfg_pkg::SAMPLE_BITS;

   // Configuration registers
   pfg_pkg::cfg_type cfg_ff, cfg_in;

   // Input register
   logic              in_valid_ff, in_valid_in;
   pfg_pkg::item_type in_item_ff, in_item_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   pfg_pkg::result_type rsp_result_ff, rsp_result_in;

   // Latched fault state
   logic [pfg_pkg::CODE_BITS-1:0] fault_ff, fault_in;
   logic [pfg_pkg::TIME_BITS-1:0] fault_time_ff, fault_time_in;

   pfg_pkg::result_type           eval_result;
   logic [pfg_pkg::CODE_BITS-1:0] eval_fault;
   logic [pfg_pkg::TIME_BITS-1:0] eval_time;

   logic req_xfer;
   logic advance;   // input register moves into the result register

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   // ---------------------------------------------------------------- config
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            pfg_pkg::REG_VOLT_HIGH:    cfg_in.volt_high = csr_data[SB-1:0];
            pfg_pkg::REG_VOLT_LOW:     cfg_in.volt_low  = csr_data[SB-1:0];
            pfg_pkg::REG_CURR_HIGH:    cfg_in.curr_high = csr_data[SB-1:0];
            pfg_pkg::REG_CURR_LOW:     cfg_in.curr_low  = csr_data[SB-1:0];
            pfg_pkg::REG_TIMEOUT_MASK:
               cfg_in.timeout_mask = csr_data[pfg_pkg::NUM_CODES-1:0];
            pfg_pkg::REG_TIMEOUT_PER:
               cfg_in.timeout_periods = csr_data[pfg_pkg::PERIODS_BITS-1:0];
            pfg_pkg::REG_RESPONSE:
               cfg_in.response_table = csr_data[pfg_pkg::RESP_TBL_BITS-1:0];
            default: ;  // unknown index: dropped
         endcase
      end
   end

   // ---------------------------------------------------------- input stage
   always_comb begin
      in_item_in.voltage_sample = req_tdata[15:0];
      in_item_in.current_sample = req_tdata[31:16];
      in_item_in.time_now       = req_tdata[63:32];
      in_item_in.pwm_duty       = req_tdata[95:64];
      in_item_in.cmd_type       = req_tuser;

      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // ------------------------------------------------------------ evaluation
   pfg_eval u_eval (
      .cfg             (cfg_ff),
      .item            (in_item_ff),
      .fault_cur       (fault_ff),
      .fault_time_cur  (fault_time_ff),
      .result          (eval_result),
      .fault_next      (eval_fault),
      .fault_time_next (eval_time)
   );

   // State and result register load only when the item actually advances
   always_comb begin
      fault_in      = advance ? eval_fault : fault_ff;
      fault_time_in = advance ? eval_time  : fault_time_ff;
      rsp_result_in = advance ? eval_result : rsp_result_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.volt_high       <= '1;
         cfg_ff.volt_low        <= '0;
         cfg_ff.curr_high       <= '1;
         cfg_ff.curr_low        <= '0;
         cfg_ff.timeout_mask    <= '0;
         cfg_ff.timeout_periods <= '0;
         cfg_ff.response_table  <= '0;
         in_valid_ff            <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         fault_ff               <= pfg_pkg::CODE_NONE;
         fault_time_ff          <= '0;
      end else begin
         cfg_ff        <= cfg_in;
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         fault_ff      <= fault_in;
         fault_time_ff <= fault_time_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff    <= req_xfer ? in_item_in : in_item_ff;
      rsp_result_ff <= rsp_result_in;
   end

   // --------------------------------------------------------------- outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000,
                        rsp_result_ff.drive_value,
                        rsp_result_ff.log_request,
                        rsp_result_ff.fault_changed,
                        rsp_result_ff.fault_code};
   assign rsp_tuser  = rsp_result_ff.drive_valid;

`ifndef SYNTHESIS
   // A log request only ever comes with a change
   a_log_needs_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_result_ff.log_request || rsp_result_ff.fault_changed))
      else $error("log_request without fault_changed");

   // A fault found in the sample is latched with that sample's time
   a_fault_stamped: assert property (@(posedge clock) disable iff (reset)
      (advance && eval_fault != pfg_pkg::CODE_NONE && eval_result.fault_changed)
      |=> (fault_time_ff == $past(in_item_ff.time_now)))
      else $error("latched fault not stamped with sample time");

   // No change means the latched state is left alone
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      (advance && !eval_result.fault_changed)
      |=> ($stable(fault_ff) && $stable(fault_time_ff)))
      else $error("fault state moved without a change");

   // State only moves when an item advances
   a_state_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(fault_ff) && $stable(fault_time_ff)))
      else $error("fault state moved without an item");

   // Latched shutoff fault forces the drive off
   a_shutoff_drive: assert property (@(posedge clock) disable iff (reset)
      (advance && eval_fault != pfg_pkg::CODE_NONE &&
       pfg_pkg::response_of(cfg_ff.response_table, eval_fault) == pfg_pkg::RESP_SHUTOFF)
      |=> (rsp_result_ff.drive_valid && rsp_result_ff.drive_value == '0))
      else $error("shutoff fault did not force drive off");
`endif

endmodule

`default_nettype wire

// ----- design/pfg_eval.sv -----
// ----------------------------------------------------------------------------
// pfg_eval
// Per-sample fault classification, timeout clearing and drive selection.
// ----------------------------------------------------------------------------
`default_nettype none

module pfg_eval (
   input  wire pfg_pkg::cfg_type                    cfg,
   input  wire pfg_pkg::item_type                   item,
   input  wire logic [pfg_pkg::CODE_BITS-1:0]       fault_cur,
   input  wire logic [pfg_pkg::TIME_BITS-1:0]       fault_time_cur,
   output pfg_pkg::result_type                      result,
   output logic [pfg_pkg::CODE_BITS-1:0]            fault_next,
   output logic [pfg_pkg::TIME_BITS-1:0]            fault_time_next
);

   logic [pfg_pkg::CODE_BITS-1:0]    found;
   logic                             tmo_en;
   logic [pfg_pkg::TIMEOUT_BITS-1:0] period;
   logic [pfg_pkg::TIME_BITS-1:0]    elapsed;
   logic                             expired;
   logic                             changed;
   logic [pfg_pkg::RESP_BITS-1:0]    resp;

   // Priority: under-V, over-V, under-I, over-I
   always_comb begin
      if (item.voltage_sample < cfg.volt_low) begin
         found = pfg_pkg::CODE_UNDER_V;
      end else if (item.voltage_sample > cfg.volt_high) begin
         found = pfg_pkg::CODE_OVER_V;
      end else if (item.current_sample < cfg.curr_low) begin
         found = pfg_pkg::CODE_UNDER_I;
      end else if (item.current_sample > cfg.curr_high) begin
         found = pfg_pkg::CODE_OVER_I;
      end else begin
         found = pfg_pkg::CODE_NONE;
      end
   end

   always_comb begin
      case (fault_cur)
         pfg_pkg::CODE_OVER_V,
         pfg_pkg::CODE_UNDER_V,
         pfg_pkg::CODE_OVER_I,
         pfg_pkg::CODE_UNDER_I,
         pfg_pkg::CODE_NONE: begin
            tmo_en = cfg.timeout_mask[fault_cur];
            period = cfg.timeout_periods[fault_cur * pfg_pkg::TIMEOUT_BITS +:
                                         pfg_pkg::TIMEOUT_BITS];
         end
         default: begin
            tmo_en = 1'b0;
            period = '0;
         end
      endcase
   end

   // Elapsed ticks wrap modulo 2^32
   assign elapsed = item.time_now - fault_time_cur;
   assign expired = tmo_en &&
                    (elapsed > {{(pfg_pkg::TIME_BITS-pfg_pkg::TIMEOUT_BITS){1'b0}}, period});

   always_comb begin
      if (found != pfg_pkg::CODE_NONE) begin
         fault_next = found;
         changed    = 1'b1;
      end else if (expired) begin
         fault_next = pfg_pkg::CODE_NONE;
         changed    = 1'b1;
      end else begin
         fault_next = fault_cur;
         changed    = 1'b0;
      end
      fault_time_next = changed ? item.time_now : fault_time_cur;
   end

   assign resp = pfg_pkg::response_of(cfg.response_table, fault_next);

   always_comb begin
      result.fault_code    = fault_next;
      result.fault_changed = changed;
      result.log_request   = changed &&
                             (resp == pfg_pkg::RESP_WARN || resp == pfg_pkg::RESP_SHUTOFF);
      if (fault_next != pfg_pkg::CODE_NONE && resp == pfg_pkg::RESP_SHUTOFF) begin
         result.drive_valid = 1'b1;
         result.drive_value = '0;
      end else begin
         case (item.cmd_type)
            pfg_pkg::CMD_ON: begin
               result.drive_valid = 1'b1;
               result.drive_value = '1;
            end
            pfg_pkg::CMD_OFF: begin
               result.drive_valid = 1'b1;
               result.drive_value = '0;
            end
            pfg_pkg::CMD_PWM: begin
               result.drive_valid = 1'b1;
               result.drive_value = item.pwm_duty;
            end
            default: begin
               result.drive_valid = 1'b0;
               result.drive_value = '0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- bench/power_channel_fault_guard_tb.sv -----
// ----------------------------------------------------------------------------
// power_channel_fault_guard_tb
// Self-checking bench for the channel fault guard. Samples go in on the req
// stream and are mirrored by a fault-latch tracker that predicts the result
// of each one. Every rsp transfer is compared field by field with the oldest
// prediction. Limits, timeouts and responses are reprogrammed between runs,
// with random back-pressure on both streams in most runs.
// ----------------------------------------------------------------------------
module power_channel_fault_guard_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pfg_pkg::*;

   localparam int WATCHDOG_LIMIT  = 20000;  // cycles without any transfer
   localparam int SETTLE_CYCLES   = 6;      // pipeline is 2 deep
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int NUM_PHASES      = 8;
   localparam int PHASE_ITEMS     = 85;

   // index the block has no register for
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED     = 3'd7;
   // response code 3, handled like ignore
   localparam logic [RESP_BITS-1:0]      RESP_AS_IGNORE = 2'd3;

   typedef enum {SET_RANDOM, SET_FLOOR, SET_CEILING, SET_SWAPPED} setting_kind_type;

   // -------------------------------------------------------------------------
   // Fault-latch tracker: register copy, latched code and time stamp, and the
   // queue of results still owed by the block.
   // -------------------------------------------------------------------------
   class fault_latch_tracker_type;
      cfg_type              regs;
      logic [CODE_BITS-1:0] latched_code;
      logic [TIME_BITS-1:0] stamp;
      result_type           expected_q[$];
      int unsigned          mismatches;

      function void reset_state();
         regs         = '0;
         regs.volt_high = '1;
         regs.curr_high = '1;
         latched_code = CODE_NONE;
         stamp        = '0;
         mismatches   = 0;
         expected_q.delete();
      endfunction

      // upper data bits beyond a register's width fall away
      function void write_reg(input logic [CSR_INDEX_BITS-1:0] reg_index,
                              input logic [CSR_DATA_BITS-1:0]  value);
         case (reg_index)
            REG_VOLT_HIGH:    regs.volt_high       = value[SAMPLE_BITS-1:0];
            REG_VOLT_LOW:     regs.volt_low        = value[SAMPLE_BITS-1:0];
            REG_CURR_HIGH:    regs.curr_high       = value[SAMPLE_BITS-1:0];
            REG_CURR_LOW:     regs.curr_low        = value[SAMPLE_BITS-1:0];
            REG_TIMEOUT_MASK: regs.timeout_mask    = value[NUM_CODES-1:0];
            REG_TIMEOUT_PER:  regs.timeout_periods = value;
            REG_RESPONSE:     regs.response_table  = value[RESP_TBL_BITS-1:0];
            default: ;
         endcase
      endfunction

      function void take_sample(input item_type s);
         logic [CODE_BITS-1:0]    found;
         logic [TIME_BITS-1:0]    elapsed;
         logic [TIMEOUT_BITS-1:0] period;
         logic [RESP_BITS-1:0]    resp;
         result_type              r;
         // fixed check order: under-V, over-V, under-I, over-I
         if (s.voltage_sample < regs.volt_low)       found = CODE_UNDER_V;
         else if (s.voltage_sample > regs.volt_high) found = CODE_OVER_V;
         else if (s.current_sample < regs.curr_low)  found = CODE_UNDER_I;
         else if (s.current_sample > regs.curr_high) found = CODE_OVER_I;
         else                                        found = CODE_NONE;
         r       = '0;
         elapsed = s.time_now - stamp;   // wraps mod 2^32
         period  = regs.timeout_periods[latched_code*TIMEOUT_BITS +: TIMEOUT_BITS];
         if (found != CODE_NONE) begin
            latched_code    = found;
            stamp           = s.time_now;
            r.fault_changed = 1'b1;
         end else if (regs.timeout_mask[latched_code] && elapsed > period) begin
            // no-fault code times out too and is re-stamped
            latched_code    = CODE_NONE;
            stamp           = s.time_now;
            r.fault_changed = 1'b1;
         end
         resp          = regs.response_table[latched_code*RESP_BITS +: RESP_BITS];
         r.fault_code  = latched_code;
         r.log_request = r.fault_changed && (resp == RESP_WARN || resp == RESP_SHUTOFF);
         if (latched_code != CODE_NONE && resp == RESP_SHUTOFF) begin
            r.drive_valid = 1'b1;
         end else begin
            case (s.cmd_type)
               CMD_ON: begin
                  r.drive_valid = 1'b1;
                  r.drive_value = '1;
               end
               CMD_OFF: r.drive_valid = 1'b1;
               CMD_PWM: begin
                  r.drive_valid = 1'b1;
                  r.drive_value = s.pwm_duty;
               end
               default: ;
            endcase
         end
         expected_q.push_back(r);
      endfunction

      function void check_outcome(input result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            $error("result transfer with no sample outstanding: %p", got);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         if (got.fault_code !== want.fault_code) begin
            $error("fault_code: expected %0d, got %0d", want.fault_code, got.fault_code);
            mismatches++;
         end
         if (got.fault_changed !== want.fault_changed) begin
            $error("fault_changed: expected %0d, got %0d",
                   want.fault_changed, got.fault_changed);
            mismatches++;
         end
         if (got.log_request !== want.log_request) begin
            $error("log_request: expected %0d, got %0d", want.log_request, got.log_request);
            mismatches++;
         end
         if (got.drive_valid !== want.drive_valid) begin
            $error("drive_valid: expected %0d, got %0d", want.drive_valid, got.drive_valid);
            mismatches++;
         end
         if (got.drive_value !== want.drive_value) begin
            $error("drive_value: expected %h, got %h", want.drive_value, got.drive_value);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and DUT
   // -------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata  = '0;
   logic [CMD_BITS-1:0] req_tuser = CMD_NONE;

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = REG_VOLT_HIGH;
   logic [CSR_DATA_BITS-1:0]  csr_data  = '0;

   always #2 clock = ~clock;

   power_channel_fault_guard uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   fault_latch_tracker_type tracker;
   cfg_type            active_cfg;       // limits in force, steers sample picking
   int                 req_idle_pct;     // sender idle chance per cycle
   int                 rsp_idle_pct;     // receiver stall chance per cycle
   logic               hold_off_request = 1'b0;
   int                 stalled_cycles   = 0;

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic item_type sample_of(input logic [SAMPLE_BITS-1:0] volt,
                                          input logic [SAMPLE_BITS-1:0] curr,
                                          input logic [TIME_BITS-1:0]   tick,
                                          input logic [CMD_BITS-1:0]    cmd,
                                          input logic [DUTY_BITS-1:0]   duty);
      item_type s;
      s.voltage_sample = volt;
      s.current_sample = curr;
      s.time_now       = tick;
      s.cmd_type       = cmd;
      s.pwm_duty       = duty;
      return s;
   endfunction

   // Mostly in range, with a fair share of values on and just past the limits
   function automatic logic [SAMPLE_BITS-1:0] pick_level(input logic [SAMPLE_BITS-1:0] lo,
                                                         input logic [SAMPLE_BITS-1:0] hi);
      logic [SAMPLE_BITS-1:0] level;
      level = SAMPLE_BITS'($urandom);
      case ($urandom_range(15))
         0: ;
         1: level = lo;
         2: level = hi;
         3: level = lo - 1'b1;
         4: level = hi + 1'b1;
         default: if (lo <= hi) level = SAMPLE_BITS'($urandom_range(hi, lo));
      endcase
      return level;
   endfunction

   // random junk above a register's width; the block has to drop it
   function automatic logic [CSR_DATA_BITS-1:0] with_stray_bits(
      input logic [CSR_DATA_BITS-1:0] value, input int width);
      logic [CSR_DATA_BITS-1:0] keep;
      logic [CSR_DATA_BITS-1:0] stray;
      keep  = '1;
      keep  = keep >> (CSR_DATA_BITS - width);
      stray = CSR_DATA_BITS'({$urandom, $urandom});
      return (value & keep) | (stray & ~keep);
   endfunction

   function automatic cfg_type random_settings(input setting_kind_type kind);
      cfg_type c;
      int      n;
      c.volt_low  = SAMPLE_BITS'($urandom_range(30000));
      c.volt_high = SAMPLE_BITS'(c.volt_low + $urandom_range(30000));
      c.curr_low  = SAMPLE_BITS'($urandom_range(30000));
      c.curr_high = SAMPLE_BITS'(c.curr_low + $urandom_range(30000));
      c.timeout_mask = NUM_CODES'($urandom);
      for (n = 0; n < NUM_CODES; n++)
         c.timeout_periods[n*TIMEOUT_BITS +: TIMEOUT_BITS] =
            TIMEOUT_BITS'($urandom_range(400));
      c.response_table = RESP_TBL_BITS'($urandom);
      case (kind)
         SET_FLOOR: c = '0;
         SET_CEILING: c = '1;
         SET_SWAPPED: begin
            // low above high: every sample faults one way or the other
            c.volt_low        = SAMPLE_BITS'($urandom_range(65535, 40000));
            c.volt_high       = SAMPLE_BITS'($urandom_range(20000));
            c.curr_low        = SAMPLE_BITS'($urandom_range(65535, 40000));
            c.curr_high       = SAMPLE_BITS'($urandom_range(20000));
            c.timeout_mask    = '1;
            c.timeout_periods = '0;
            c.response_table  = {NUM_CODES{RESP_SHUTOFF}};
         end
         default: ;
      endcase
      return c;
   endfunction

   // csr_valid stays high across back-to-back writes; apply_settings drops it
   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] reg_index,
                            input logic [CSR_DATA_BITS-1:0]  value);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(reg_index, value);
   endtask

   task automatic apply_settings(input cfg_type c);
      active_cfg = c;
      csr_write(REG_VOLT_HIGH,
                with_stray_bits(CSR_DATA_BITS'(c.volt_high), SAMPLE_BITS));
      csr_write(REG_VOLT_LOW,
                with_stray_bits(CSR_DATA_BITS'(c.volt_low), SAMPLE_BITS));
      csr_write(REG_CURR_HIGH,
                with_stray_bits(CSR_DATA_BITS'(c.curr_high), SAMPLE_BITS));
      csr_write(REG_CURR_LOW,
                with_stray_bits(CSR_DATA_BITS'(c.curr_low), SAMPLE_BITS));
      csr_write(REG_TIMEOUT_MASK,
                with_stray_bits(CSR_DATA_BITS'(c.timeout_mask), NUM_CODES));
      csr_write(REG_TIMEOUT_PER,  c.timeout_periods);
      csr_write(REG_RESPONSE,
                with_stray_bits(CSR_DATA_BITS'(c.response_table), RESP_TBL_BITS));
      csr_write(REG_UNUSED,       with_stray_bits('0, 0));
      csr_valid <= 1'b0;
   endtask

   // req_tvalid is left high after a transfer and only dropped for a gap,
   // so back-to-back items never see two assignments in one step
   task automatic send_item(input item_type s);
      if ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {s.pwm_duty, s.time_now, s.current_sample, s.voltage_sample};
      req_tuser  <= s.cmd_type;
      do @(posedge clock); while (!req_tready);
      tracker.take_sample(s);
   endtask

   // stop offering, let every owed result come back, then let the pipe settle
   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Result side: random stalls, one long hold-off on request, and checking
   // -------------------------------------------------------------------------
   initial begin : result_sink
      result_type got;
      int         hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.fault_code    = rsp_tdata[2:0];
            got.fault_changed = rsp_tdata[3];
            got.log_request   = rsp_tdata[4];
            got.drive_value   = rsp_tdata[36:5];
            got.drive_valid   = rsp_tuser;
            tracker.check_outcome(got);
         end
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left        = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Watchdog: a run that stops moving is a failure
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      cfg_type              dir_cfg;
      item_type             s;
      setting_kind_type     kind;
      logic [TIME_BITS-1:0] tick_now;
      int                   phase;
      int                   k;

      tracker = new;
      tracker.reset_state();
      req_idle_pct = 38;
      rsp_idle_pct = 70;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset values: full-scale limits, no timeouts, all responses ignore
      send_item(sample_of(16'h0000, 16'h0000, 32'd0, CMD_ON, 32'h0000_0000));
      send_item(sample_of(16'hFFFF, 16'hFFFF, 32'd5, CMD_PWM, 32'hFFFF_FFFF));
      send_item(sample_of(16'd12345, 16'd54321, 32'd9, CMD_NONE, 32'h1234_5678));
      wait_until_drained();

      // Directed settings: distinct period per code, every response kind
      dir_cfg.volt_low        = 16'd1000;
      dir_cfg.volt_high       = 16'd5000;
      dir_cfg.curr_low        = 16'd100;
      dir_cfg.curr_high       = 16'd2000;
      dir_cfg.timeout_mask    = '1;
      dir_cfg.timeout_periods = {12'd50, 12'd40, 12'd30, 12'd20, 12'd10};
      dir_cfg.response_table  = {RESP_SHUTOFF, RESP_AS_IGNORE, RESP_IGNORE,
                                 RESP_WARN, RESP_SHUTOFF};
      apply_settings(dir_cfg);

      // no-fault code times out, logs on shutoff but keeps the drive
      send_item(sample_of(16'd3000, 16'd1000, 32'd100, CMD_ON, 32'h0));
      // under-voltage, then repeated: re-latched every item
      send_item(sample_of(16'd999, 16'd1000, 32'd110, CMD_PWM, 32'hA5A5_A5A5));
      send_item(sample_of(16'd999, 16'd1000, 32'd115, CMD_OFF, 32'h0));
      // elapsed equal to the period holds, one tick more clears
      send_item(sample_of(16'd3000, 16'd1000, 32'd135, CMD_ON, 32'h0));
      send_item(sample_of(16'd3000, 16'd1000, 32'd136, CMD_ON, 32'h0));
      // over-voltage outranks over-current; shutoff forces drive off
      send_item(sample_of(16'd5001, 16'd2001, 32'd140, CMD_ON, 32'h0));
      send_item(sample_of(16'd5000, 16'd1000, 32'd145, CMD_PWM, 32'h5A5A_5A5A));
      // under-current with response three: no log; no-command item
      send_item(sample_of(16'd1000, 16'd99, 32'd160, CMD_NONE, 32'hFFFF_0000));
      // sample extremes, check order decides
      send_item(sample_of(16'h0000, 16'hFFFF, 32'd170, CMD_ON, 32'h0));
      send_item(sample_of(16'hFFFF, 16'h0000, 32'd180, CMD_PWM, 32'h0));
      // over-current with ignore response
      send_item(sample_of(16'd3000, 16'd2001, 32'd200, CMD_ON, 32'h0));
      send_item(sample_of(16'd3000, 16'd2000, 32'd231, CMD_OFF, 32'h0));
      // timeout across the 32-bit wrap of the tick counter
      send_item(sample_of(16'd999, 16'd1000, 32'hFFFF_FFF0, CMD_ON, 32'h0));
      send_item(sample_of(16'd3000, 16'd1000, 32'h0000_0004, CMD_ON, 32'h0));
      send_item(sample_of(16'd3000, 16'd1000, 32'h0000_0005, CMD_NONE, 32'h0));
      send_item(sample_of(16'd3000, 16'd1000, 32'h0000_0006, CMD_PWM, 32'hFFFF_FFFF));
      // tick going backwards reads as a huge elapsed time
      send_item(sample_of(16'd3000, 16'd1000, 32'h0000_0000, CMD_ON, 32'h0));
      send_item(sample_of(16'hFFFF, 16'hFFFF, 32'h0000_0001, CMD_OFF, 32'h0));
      wait_until_drained();

      // Random runs, each with fresh settings. Idling: sender light and
      // receiver heavy, then swapped, then none at all.
      tick_now = 32'd1;
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase < 3) begin
            req_idle_pct = 38;
            rsp_idle_pct = 70;
         end else if (phase < 6) begin
            req_idle_pct = 70;
            rsp_idle_pct = 38;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         case (phase)
            1:       kind = SET_FLOOR;
            3:       kind = SET_CEILING;
            5:       kind = SET_SWAPPED;
            default: kind = SET_RANDOM;
         endcase
         apply_settings(random_settings(kind));

         for (k = 0; k < PHASE_ITEMS; k++) begin
            // small steps so timeouts land on both sides of their periods
            if ($urandom_range(19) == 0) tick_now = $urandom;
            else                         tick_now = tick_now + $urandom_range(120);
            s = sample_of(pick_level(active_cfg.volt_low, active_cfg.volt_high),
                          pick_level(active_cfg.curr_low, active_cfg.curr_high),
                          tick_now, CMD_BITS'($urandom_range(3)), $urandom);
            send_item(s);
            // sender pauses until the block has handed back everything
            if (phase == 1 && k == 40) wait_until_drained();
            // receiver goes quiet while items keep coming: block fills up
            if (phase == 6 && k == 30) hold_off_request = 1'b1;
         end
         wait_until_drained();
      end

      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/pfg_pkg.sv
design/pfg_eval.sv
design/power_channel_fault_guard.sv
bench/power_channel_fault_guard_tb.sv
